// ===== rtl/avrdec_pkg.sv =====
// ----------------------------------------------------------------------------
// avrdec_pkg
// Shared types and encodings for the AVR instruction subset decoder:
// instruction classes, match masks and patterns, and the decoded result.
// ----------------------------------------------------------------------------
package avrdec_pkg;

    localparam int unsigned INSTR_W  = 16;
    localparam int unsigned CLASS_W  = 5;
    localparam int unsigned REG_W    = 5;
    localparam int unsigned IMM_W    = 8;
    localparam int unsigned OFFSET_W = 13;

    // Output beat: class, dest, src, imm, offset packed from bit 0, padded to bytes
    localparam int unsigned RESULT_BITS = CLASS_W + 2 * REG_W + IMM_W + OFFSET_W;
    localparam int unsigned IN_TDATA_W  = ((INSTR_W + 7) / 8) * 8;
    localparam int unsigned OUT_TDATA_W = ((RESULT_BITS + 7) / 8) * 8;

    // Instruction classes, in the encoding seen on the output
    typedef enum logic [CLASS_W-1:0] {
        OP_NOP     = 5'd0,
        OP_CLR     = 5'd1,
        OP_LDI     = 5'd2,
        OP_LD_XP   = 5'd3,
        OP_LD_YP   = 5'd4,
        OP_LD_MX   = 5'd5,
        OP_CPI     = 5'd6,
        OP_BRNE    = 5'd7,
        OP_SBIW    = 5'd8,
        OP_RCALL   = 5'd9,
        OP_SBC     = 5'd10,
        OP_ADC     = 5'd11,
        OP_MOVW    = 5'd12,
        OP_SUBI    = 5'd13,
        OP_ORI     = 5'd14,
        OP_CP      = 5'd15,
        OP_MOV     = 5'd16,
        OP_INC     = 5'd17,
        OP_DEC     = 5'd18,
        OP_UNKNOWN = 5'd19
    } t_op_class;

    // Opcode masks
    localparam logic [INSTR_W-1:0] MASK_TOP4  = 16'hF000;
    localparam logic [INSTR_W-1:0] MASK_TOP6  = 16'hFC00;
    localparam logic [INSTR_W-1:0] MASK_TOP8  = 16'hFF00;
    localparam logic [INSTR_W-1:0] MASK_ONE_R = 16'hFE0F;
    localparam logic [INSTR_W-1:0] MASK_BRBC  = 16'hFC07;

    // Opcode patterns
    localparam logic [INSTR_W-1:0] PAT_NOP   = 16'h0000;
    localparam logic [INSTR_W-1:0] PAT_EOR   = 16'h2400;
    localparam logic [INSTR_W-1:0] PAT_LDI   = 16'hE000;
    localparam logic [INSTR_W-1:0] PAT_LD_XP = 16'h900D;
    localparam logic [INSTR_W-1:0] PAT_LD_YP = 16'h9009;
    localparam logic [INSTR_W-1:0] PAT_LD_MX = 16'h900E;
    localparam logic [INSTR_W-1:0] PAT_CPI   = 16'h3000;
    localparam logic [INSTR_W-1:0] PAT_BRNE  = 16'hF401;
    localparam logic [INSTR_W-1:0] PAT_SBIW  = 16'h9700;
    localparam logic [INSTR_W-1:0] PAT_RCALL = 16'hD000;
    localparam logic [INSTR_W-1:0] PAT_SBC   = 16'h0800;
    localparam logic [INSTR_W-1:0] PAT_ADC   = 16'h1C00;
    localparam logic [INSTR_W-1:0] PAT_MOVW  = 16'h0100;
    localparam logic [INSTR_W-1:0] PAT_SUBI  = 16'h5000;
    localparam logic [INSTR_W-1:0] PAT_ORI   = 16'h6000;
    localparam logic [INSTR_W-1:0] PAT_CP    = 16'h1400;
    localparam logic [INSTR_W-1:0] PAT_MOV   = 16'h2C00;
    localparam logic [INSTR_W-1:0] PAT_INC   = 16'h9403;
    localparam logic [INSTR_W-1:0] PAT_DEC   = 16'h940A;

    // Decoded result of one word
    typedef struct packed {
        logic signed [OFFSET_W-1:0] branch_offset;
        logic [IMM_W-1:0]           imm_value;
        logic [REG_W-1:0]           src_reg;
        logic [REG_W-1:0]           dest_reg;
        t_op_class                  op_class;
    } t_decode;

endpackage

// ===== rtl/avrdec_decode.sv =====
// ----------------------------------------------------------------------------
// avrdec_decode
// Combinational priority decode of one AVR instruction word into class,
// register numbers, immediate and relative offset plus one.
// ----------------------------------------------------------------------------
module avrdec_decode
    import avrdec_pkg::*;
(
    input  logic [INSTR_W-1:0] i_word,
    output t_decode            o_dec
);

    logic [REG_W-1:0]           d5;
    logic [REG_W-1:0]           r5;
    logic [REG_W-1:0]           d4hi;
    logic [IMM_W-1:0]           k8;
    logic signed [OFFSET_W-1:0] brne_off;
    logic signed [OFFSET_W-1:0] rcall_off;

    // Extract the common operand fields
    assign d5        = i_word[8:4];
    assign r5        = {i_word[9], i_word[3:0]};
    assign d4hi      = {1'b1, i_word[7:4]};
    assign k8        = {i_word[11:8], i_word[3:0]};
    assign brne_off  = {{(OFFSET_W-7){i_word[9]}}, i_word[9:3]} + OFFSET_W'(1);
    assign rcall_off = {{(OFFSET_W-12){i_word[11]}}, i_word[11:0]} + OFFSET_W'(1);

    // Match patterns in priority order, first hit wins
    always_comb begin
        o_dec = '{branch_offset: '0, imm_value: '0, src_reg: '0, dest_reg: '0,
                  op_class: OP_UNKNOWN};
        priority if (i_word == PAT_NOP) begin
            o_dec.op_class = OP_NOP;
        end else if ((i_word & MASK_TOP6) == PAT_EOR && d5 == r5) begin
            o_dec.op_class = OP_CLR;
            o_dec.dest_reg = d5;
        end else if ((i_word & MASK_TOP4) == PAT_LDI) begin
            o_dec.op_class  = OP_LDI;
            o_dec.dest_reg  = d4hi;
            o_dec.imm_value = k8;
        end else if ((i_word & MASK_ONE_R) == PAT_LD_XP) begin
            o_dec.op_class = OP_LD_XP;
            o_dec.dest_reg = d5;
        end else if ((i_word & MASK_ONE_R) == PAT_LD_YP) begin
            o_dec.op_class = OP_LD_YP;
            o_dec.dest_reg = d5;
        end else if ((i_word & MASK_ONE_R) == PAT_LD_MX) begin
            o_dec.op_class = OP_LD_MX;
            o_dec.dest_reg = d5;
        end else if ((i_word & MASK_TOP4) == PAT_CPI) begin
            o_dec.op_class  = OP_CPI;
            o_dec.dest_reg  = d4hi;
            o_dec.imm_value = k8;
        end else if ((i_word & MASK_BRBC) == PAT_BRNE) begin
            o_dec.op_class      = OP_BRNE;
            o_dec.branch_offset = brne_off;
        end else if ((i_word & MASK_TOP8) == PAT_SBIW) begin
            o_dec.op_class  = OP_SBIW;
            o_dec.dest_reg  = {2'b11, i_word[5:4], 1'b0};
            o_dec.imm_value = {2'b00, i_word[7:6], i_word[3:0]};
        end else if ((i_word & MASK_TOP4) == PAT_RCALL) begin
            o_dec.op_class      = OP_RCALL;
            o_dec.branch_offset = rcall_off;
        end else if ((i_word & MASK_TOP6) == PAT_SBC) begin
            o_dec.op_class = OP_SBC;
            o_dec.dest_reg = d5;
            o_dec.src_reg  = r5;
        end else if ((i_word & MASK_TOP6) == PAT_ADC) begin
            o_dec.op_class = OP_ADC;
            o_dec.dest_reg = d5;
            o_dec.src_reg  = r5;
        end else if ((i_word & MASK_TOP8) == PAT_MOVW) begin
            o_dec.op_class = OP_MOVW;
            o_dec.dest_reg = {i_word[7:4], 1'b0};
            o_dec.src_reg  = {i_word[3:0], 1'b0};
        end else if ((i_word & MASK_TOP4) == PAT_SUBI) begin
            o_dec.op_class  = OP_SUBI;
            o_dec.dest_reg  = d4hi;
            o_dec.imm_value = k8;
        end else if ((i_word & MASK_TOP4) == PAT_ORI) begin
            o_dec.op_class  = OP_ORI;
            o_dec.dest_reg  = d4hi;
            o_dec.imm_value = k8;
        end else if ((i_word & MASK_TOP6) == PAT_CP) begin
            o_dec.op_class = OP_CP;
            o_dec.dest_reg = d5;
            o_dec.src_reg  = r5;
        end else if ((i_word & MASK_TOP6) == PAT_MOV) begin
            o_dec.op_class = OP_MOV;
            o_dec.dest_reg = d5;
            o_dec.src_reg  = r5;
        end else if ((i_word & MASK_ONE_R) == PAT_INC) begin
            o_dec.op_class = OP_INC;
            o_dec.dest_reg = d5;
        end else if ((i_word & MASK_ONE_R) == PAT_DEC) begin
            o_dec.op_class = OP_DEC;
            o_dec.dest_reg = d5;
        end else begin
            o_dec.op_class = OP_UNKNOWN;
        end
    end

endmodule

// ===== rtl/avr_opcode_subset_decoder.sv =====
// ----------------------------------------------------------------------------
// avr_opcode_subset_decoder
// Streaming decoder for a subset of AVR instruction words.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream: one 16-bit instruction word per beat on i_s_axis_tdata.
//   Master stream: one decoded beat per input beat on o_m_axis_tdata, in order:
//   class, destination register, source register, immediate, offset plus one.
//   Structure: input word register, priority decode logic, result register.
//   Path: an accepted word is held in the input word register, decoded, and
//   the result is registered before it is presented on the master side.
//   Throughput: one word per cycle, sustained while the master side takes a
//   beat every cycle; both registers advance together.
//   Stall: when the master side holds tready low, the result register holds,
//   the input register fills, and then tready on the slave side drops. Any
//   empty slot is refilled at once, so no bubble is inserted on release.
//   Reset: synchronous, active low; both stage valid flags clear, slave
//   tready stays low while reset is held, and the block comes out of reset
//   ready to take a word. Payload is not reset.
// ----------------------------------------------------------------------------
module avr_opcode_subset_decoder
    import avrdec_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // Fields from bit 0: instr_word[15:0]
    input  logic [IN_TDATA_W-1:0]  i_s_axis_tdata,
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    // Fields from bit 0: op_class[4:0], dest_reg[9:5], src_reg[14:10],
    // imm_value[22:15], branch_offset[35:23], zero pad[39:36]
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata,
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready
);

    logic               r_in_valid;
    logic [INSTR_W-1:0] r_in_word;
    logic               r_out_valid;
    t_decode            r_out_dec;
    t_decode            n_out_dec;
    logic               out_advance;
    logic               in_advance;

    // Move a stage forward when the stage after it is empty or draining
    assign out_advance     = !r_out_valid || i_m_axis_tready;
    assign in_advance      = !r_in_valid || out_advance;
    assign o_s_axis_tready = in_advance && i_rst_n;

    // Capture the incoming word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_advance) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_advance && i_s_axis_tvalid) begin
            r_in_word <= i_s_axis_tdata[INSTR_W-1:0];
        end
    end

    // Decode the registered word
    avrdec_decode u_decode (
        .i_word (r_in_word),
        .o_dec  (n_out_dec)
    );

    // Hold the result until the master side takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_advance && r_in_valid) begin
            r_out_dec <= n_out_dec;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{(OUT_TDATA_W-RESULT_BITS){1'b0}}, r_out_dec};

endmodule

// ===== dv/avr_opcode_subset_decoder_tb.sv =====
// ----------------------------------------------------------------------------
// avr_opcode_subset_decoder testbench
// Streams AVR instruction words into the decoder and checks every decoded
// beat against an in-order prediction of class, registers, immediate and
// branch offset. A directed set of corner words is followed by random
// words, mostly well-formed encodings of each supported instruction with
// random operands and the rest raw noise. Both stream sides idle at random,
// the receiver holds off once long enough to back up the input, and the
// sender drains the pipe once midway.
// ----------------------------------------------------------------------------
module tb
    import avrdec_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned RANDOM_WORDS  = 1900;
    localparam int unsigned IDLE_LIMIT    = 2000;
    localparam int unsigned HOLDOFF_BEAT  = 400;
    localparam int unsigned HOLDOFF_LEN   = 300;
    localparam int unsigned DRAIN_AT_WORD = 900;
    localparam int unsigned NUM_CLASSES   = 20;

    // Expected decodes in arrival order, checked against each output beat
    class decode_scoreboard;
        t_decode     pending_decodes[$];
        int unsigned errors;
        int unsigned beats_checked;
        int unsigned class_hits[NUM_CLASSES];

        function new();
            errors        = 0;
            beats_checked = 0;
            foreach (class_hits[i]) class_hits[i] = 0;
        endfunction

        // Priority decode of one word, first match wins
        function t_decode decode_word(logic [INSTR_W-1:0] w);
            t_decode        r;
            logic [REG_W-1:0] d5;
            logic [REG_W-1:0] r5;
            logic [REG_W-1:0] d4hi;
            logic [IMM_W-1:0] k8;
            r          = '0;
            r.op_class = OP_UNKNOWN;
            d5   = w[8:4];
            r5   = {w[9], w[3:0]};
            d4hi = {1'b1, w[7:4]};
            k8   = {w[11:8], w[3:0]};
            if (w == PAT_NOP) begin
                r.op_class = OP_NOP;
            end else if ((w & MASK_TOP6) == PAT_EOR && d5 == r5) begin
                r.op_class = OP_CLR;   r.dest_reg = d5;
            end else if ((w & MASK_TOP4) == PAT_LDI) begin
                r.op_class = OP_LDI;   r.dest_reg = d4hi; r.imm_value = k8;
            end else if ((w & MASK_ONE_R) == PAT_LD_XP) begin
                r.op_class = OP_LD_XP; r.dest_reg = d5;
            end else if ((w & MASK_ONE_R) == PAT_LD_YP) begin
                r.op_class = OP_LD_YP; r.dest_reg = d5;
            end else if ((w & MASK_ONE_R) == PAT_LD_MX) begin
                r.op_class = OP_LD_MX; r.dest_reg = d5;
            end else if ((w & MASK_TOP4) == PAT_CPI) begin
                r.op_class = OP_CPI;   r.dest_reg = d4hi; r.imm_value = k8;
            end else if ((w & MASK_BRBC) == PAT_BRNE) begin
                r.op_class      = OP_BRNE;
                r.branch_offset = $signed({{6{w[9]}}, w[9:3]}) + 13'sd1;
            end else if ((w & MASK_TOP8) == PAT_SBIW) begin
                r.op_class  = OP_SBIW;
                r.dest_reg  = {2'b11, w[5:4], 1'b0};
                r.imm_value = {2'b00, w[7:6], w[3:0]};
            end else if ((w & MASK_TOP4) == PAT_RCALL) begin
                r.op_class      = OP_RCALL;
                r.branch_offset = $signed({w[11], w[11:0]}) + 13'sd1;
            end else if ((w & MASK_TOP6) == PAT_SBC) begin
                r.op_class = OP_SBC;   r.dest_reg = d5; r.src_reg = r5;
            end else if ((w & MASK_TOP6) == PAT_ADC) begin
                r.op_class = OP_ADC;   r.dest_reg = d5; r.src_reg = r5;
            end else if ((w & MASK_TOP8) == PAT_MOVW) begin
                r.op_class = OP_MOVW;
                r.dest_reg = {w[7:4], 1'b0};
                r.src_reg  = {w[3:0], 1'b0};
            end else if ((w & MASK_TOP4) == PAT_SUBI) begin
                r.op_class = OP_SUBI;  r.dest_reg = d4hi; r.imm_value = k8;
            end else if ((w & MASK_TOP4) == PAT_ORI) begin
                r.op_class = OP_ORI;   r.dest_reg = d4hi; r.imm_value = k8;
            end else if ((w & MASK_TOP6) == PAT_CP) begin
                r.op_class = OP_CP;    r.dest_reg = d5; r.src_reg = r5;
            end else if ((w & MASK_TOP6) == PAT_MOV) begin
                r.op_class = OP_MOV;   r.dest_reg = d5; r.src_reg = r5;
            end else if ((w & MASK_ONE_R) == PAT_INC) begin
                r.op_class = OP_INC;   r.dest_reg = d5;
            end else if ((w & MASK_ONE_R) == PAT_DEC) begin
                r.op_class = OP_DEC;   r.dest_reg = d5;
            end
            return r;
        endfunction

        function void note_word(logic [IN_TDATA_W-1:0] beat);
            pending_decodes.push_back(decode_word(beat[INSTR_W-1:0]));
        endfunction

        function void field_mismatch(string field, int want, int got);
            if (want != got) begin
                $display("%0t ns: %s mismatch, expected %0d, actual %0d",
                         $time, field, want, got);
                errors++;
            end
        endfunction

        function void check_beat(logic [OUT_TDATA_W-1:0] beat);
            t_decode got;
            t_decode want;
            got = t_decode'(beat[RESULT_BITS-1:0]);
            if (pending_decodes.size() == 0) begin
                $display("%0t ns: unexpected beat, expected none, actual 0x%0h",
                         $time, beat);
                errors++;
                return;
            end
            want = pending_decodes.pop_front();
            beats_checked++;
            class_hits[want.op_class]++;
            field_mismatch("op_class", int'(want.op_class), int'(got.op_class));
            field_mismatch("dest_reg", want.dest_reg, got.dest_reg);
            field_mismatch("src_reg", want.src_reg, got.src_reg);
            field_mismatch("imm_value", want.imm_value, got.imm_value);
            field_mismatch("branch_offset", int'(want.branch_offset),
                           int'(got.branch_offset));
            field_mismatch("pad bits", 0, int'(beat[OUT_TDATA_W-1:RESULT_BITS]));
        endfunction

        function int unsigned outstanding();
            return pending_decodes.size();
        endfunction

        // Flag decodes that never came out, then summarize
        function void close_out(int unsigned words_sent);
            int unsigned classes_seen;
            if (pending_decodes.size() != 0) begin
                $display("%0t ns: missing beats, expected 0 outstanding, actual %0d",
                         $time, pending_decodes.size());
                errors++;
            end
            classes_seen = 0;
            foreach (class_hits[i]) if (class_hits[i] != 0) classes_seen++;
            $display("Streamed %0d instruction words, checked %0d decoded beats.",
                     words_sent, beats_checked);
            $display("Decoded %0d of %0d instruction classes, %0d mismatches.",
                     classes_seen, NUM_CLASSES, errors);
        endfunction
    endclass

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;

    decode_scoreboard sb;
    int unsigned      words_sent = 0;
    int unsigned      idle_cycles = 0;

    avr_opcode_subset_decoder i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready)
    );

    always #5 i_clk = ~i_clk;

    // Note accepted words and check accepted results
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_tvalid && s_tready) sb.note_word(s_tdata);
            if (m_tvalid && m_tready) sb.check_beat(m_tdata);
        end
    end

    // Abort when neither side moves a beat for too long
    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t ns: no beat moved for %0d cycles", $time, IDLE_LIMIT);
            $display("avr_opcode_subset_decoder regression: fail");
            $finish;
        end
    end

    // Build a word of one supported encoding with random operands
    function automatic logic [INSTR_W-1:0] random_encoding(t_op_class kind);
        logic [INSTR_W-1:0] mask;
        logic [INSTR_W-1:0] pat;
        logic [INSTR_W-1:0] noise;
        logic [REG_W-1:0]   d;
        noise = INSTR_W'($urandom);
        d     = REG_W'($urandom);
        mask  = MASK_TOP4;
        pat   = PAT_LDI;
        unique case (kind)
            OP_NOP:   return PAT_NOP;
            OP_CLR:   return PAT_EOR | {6'b0, d[4], d[4], d[3:0], d[3:0]};
            OP_LDI:   begin mask = MASK_TOP4;  pat = PAT_LDI;   end
            OP_LD_XP: begin mask = MASK_ONE_R; pat = PAT_LD_XP; end
            OP_LD_YP: begin mask = MASK_ONE_R; pat = PAT_LD_YP; end
            OP_LD_MX: begin mask = MASK_ONE_R; pat = PAT_LD_MX; end
            OP_CPI:   begin mask = MASK_TOP4;  pat = PAT_CPI;   end
            OP_BRNE:  begin mask = MASK_BRBC;  pat = PAT_BRNE;  end
            OP_SBIW:  begin mask = MASK_TOP8;  pat = PAT_SBIW;  end
            OP_RCALL: begin mask = MASK_TOP4;  pat = PAT_RCALL; end
            OP_SBC:   begin mask = MASK_TOP6;  pat = PAT_SBC;   end
            OP_ADC:   begin mask = MASK_TOP6;  pat = PAT_ADC;   end
            OP_MOVW:  begin mask = MASK_TOP8;  pat = PAT_MOVW;  end
            OP_SUBI:  begin mask = MASK_TOP4;  pat = PAT_SUBI;  end
            OP_ORI:   begin mask = MASK_TOP4;  pat = PAT_ORI;   end
            OP_CP:    begin mask = MASK_TOP6;  pat = PAT_CP;    end
            OP_MOV:   begin mask = MASK_TOP6;  pat = PAT_MOV;   end
            OP_INC:   begin mask = MASK_ONE_R; pat = PAT_INC;   end
            OP_DEC:   begin mask = MASK_ONE_R; pat = PAT_DEC;   end
            default:  begin mask = MASK_TOP6;  pat = PAT_EOR;   end
        endcase
        return (noise & ~mask) | pat;
    endfunction

    // Offer one word after a gap and hold it until the decoder takes it
    task automatic send_word(input logic [INSTR_W-1:0] w, input int gap);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tdata  <= w;
        s_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        words_sent++;
    endtask

    // Receiver: random stalls per beat, calm stretches, one long hold-off
    initial begin : result_sink
        int unsigned beats;
        int          stall;
        bit          calm;
        beats = 0;
        calm  = 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (beats % 64 == 0) calm = ($urandom_range(0, 3) == 0);
            stall = calm ? 0 : $urandom_range(0, 10);
            if (beats == HOLDOFF_BEAT) stall = HOLDOFF_LEN;
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_tready <= 1'b1;
            @(posedge i_clk);
            while (!m_tvalid) @(posedge i_clk);
            beats++;
        end
    end

    initial begin : word_source
        logic [INSTR_W-1:0] directed[$];
        int                 gap;
        bit                 calm;
        sb = new();

        // Corner words: field extremes, every class, EOR and BRBC lookalikes
        directed = {16'h0000, 16'hFFFF, 16'h2400, 16'h27FF, 16'h2401,
                    16'hE000, 16'hEFFF, 16'h900D, 16'h91FD, 16'h9009,
                    16'h900E, 16'h3FFF, 16'hF601, 16'hF5F9, 16'hF400,
                    16'h97FF, 16'h9700, 16'hD800, 16'hD7FF, 16'h0BFF,
                    16'h1C00, 16'h01FF, 16'h5A5A, 16'h6FFF, 16'h17FF,
                    16'h2C00, 16'h95F3, 16'h940A};

        // Hold reset low, then release it
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[i]) send_word(directed[i], $urandom_range(0, 2));

        calm = 1'b0;
        for (int unsigned n = 0; n < RANDOM_WORDS; n++) begin
            if (n % 50 == 0) calm = ($urandom_range(0, 3) == 0);
            // Drain the pipe once: wait for every outstanding result
            if (n == DRAIN_AT_WORD) begin
                s_tvalid <= 1'b0;
                @(posedge i_clk);
                while (sb.outstanding() != 0) @(posedge i_clk);
            end
            gap = calm ? 0 : $urandom_range(0, 10);
            if ($urandom_range(0, 9) < 7) begin
                send_word(random_encoding(t_op_class'($urandom_range(0, 19))), gap);
            end else begin
                send_word(INSTR_W'($urandom), gap);
            end
        end
        s_tvalid <= 1'b0;

        // Wait out the outstanding results and the pipeline depth
        @(posedge i_clk);
        while (sb.outstanding() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        sb.close_out(words_sent);
        if (sb.errors == 0) begin
            $display("avr_opcode_subset_decoder regression: pass");
        end else begin
            $display("avr_opcode_subset_decoder regression: fail");
        end
        $finish;
    end

endmodule
